// ----- rtl/ste_pkg.sv -----
// ----------------------------------------------------------------------------
// ste_pkg: shared types, constants and helpers
// Frame layout constants, the record passed from the front converter to the
// back serializer, and the character helpers both halves use.
// ----------------------------------------------------------------------------
package ste_pkg;

  // Frame and sequence constants
  localparam int unsigned SEQ_MODULUS = 1000;
  localparam int unsigned SEQ_W       = 10;
  localparam int unsigned FRAME_LEN   = 44;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CSUM_MOD    = 1000;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned GROUPS      = 9;    // checksum bytes 3..38, four at a time
  localparam int unsigned ANA_W       = 12;
  localparam int unsigned IN_W        = 96;
  localparam int unsigned IN_USED     = 93;
  localparam int unsigned BYTE_W      = 8;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  // ASCII characters
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_HEXA = 8'h37;  // 'A' - 10
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Fully converted frame contents
  typedef struct packed {
    logic [11:0] seq_bcd;   // three BCD digits, most significant first
    logic [47:0] hex;       // x, y, z with x in the top bits
    logic [47:0] dec;       // a, b, c as four BCD digits each, a on top
    logic [7:0]  bits;
    logic        btn;
    logic [11:0] csum_bcd;  // three BCD digits
  } frame_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CONV,
    F_SUM,
    F_MOD,
    F_CCONV,
    F_PUSH
  } front_state_e;

  // One double-dabble step: add 3 to digits above 4, then shift in a bit
  function automatic logic [15:0] bcd_step(logic [15:0] bcd, logic b);
    logic [15:0] adj;
    for (int i = 0; i < 4; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    return {adj[14:0], b};
  endfunction

  // Uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + {4'b0, nib} : CH_HEXA + {4'b0, nib};
  endfunction

  // Frame byte at a position
  function automatic logic [7:0] byte_at(frame_rec_t r, logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] n;
    logic [3:0]       nib;
    logic [7:0]       ch;
    n   = '0;
    nib = '0;
    ch  = CH_LF;
    if (idx < 6'd3) begin
      ch = CH_HASH;
    end else if (idx < 6'd6) begin
      n   = idx - 6'd3;
      nib = r.seq_bcd[6'd11 - {n[3:0], 2'b00} -: 4];
      ch  = CH_ZERO + {4'b0, nib};
    end else if (idx < 6'd18) begin
      n   = idx - 6'd6;
      nib = r.hex[6'd47 - {n[3:0], 2'b00} -: 4];
      ch  = hex_char(nib);
    end else if (idx < 6'd30) begin
      n   = idx - 6'd18;
      nib = r.dec[6'd47 - {n[3:0], 2'b00} -: 4];
      ch  = CH_ZERO + {4'b0, nib};
    end else if (idx < 6'd38) begin
      n  = idx - 6'd30;
      ch = CH_ZERO + {7'b0, r.bits[3'd7 - n[2:0]]};
    end else if (idx == 6'd38) begin
      ch = CH_ZERO + {7'b0, r.btn};
    end else if (idx < 6'd42) begin
      n   = idx - 6'd39;
      nib = r.csum_bcd[6'd11 - {n[3:0], 2'b00} -: 4];
      ch  = CH_ZERO + {4'b0, nib};
    end else if (idx == 6'd42) begin
      ch = CH_CR;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/ste_front.sv -----
// ----------------------------------------------------------------------------
// ste_front: sample intake and conversion
// Buffers one sample set, converts the readings and the checksum to decimal
// with a shared sequencer, and pushes the finished record into the queue.
// ----------------------------------------------------------------------------
module ste_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [ste_pkg::IN_USED-1:0]   s_tdata_i,
  output logic                          push_o,
  output ste_pkg::frame_rec_t           rec_o,
  input  ste_pkg::q_stat_t              q_stat_i
);

  ste_pkg::front_state_e state_q, state_d;

  logic                          hold_valid_q, hold_valid_d;
  logic [ste_pkg::IN_USED-1:0]   hold_q;
  logic                          s_accept;
  logic                          take;

  logic [3:0]                    cnt_q, cnt_d;
  logic [47:0]                   hex_q;
  logic [7:0]                    bits_q;
  logic                          btn_q;
  logic [ste_pkg::ANA_W-1:0]     sh_a_q, sh_b_q, sh_c_q;
  logic [15:0]                   bcd_a_q, bcd_b_q, bcd_c_q;
  logic [ste_pkg::SUM_W-1:0]     sum_q;
  logic [ste_pkg::SEQ_W-1:0]     csh_q;
  logic [15:0]                   cbcd_q;
  logic [ste_pkg::SEQ_W-1:0]     seq_bin_q;
  logic [11:0]                   seq_bcd_q;

  logic [ste_pkg::IDX_W-1:0]     grp_base;
  logic [ste_pkg::SUM_W-1:0]     grp_sum;
  logic                          sum_big;

  // Input holding register
  assign s_tready_o = !hold_valid_q;
  assign s_accept   = s_tvalid_i && !hold_valid_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (take) begin
      hold_valid_d = 1'b0;
    end else if (s_accept) begin
      hold_valid_d = 1'b1;
    end
  end

  // Record as currently assembled
  always_comb begin
    rec_o.seq_bcd  = seq_bcd_q;
    rec_o.hex      = hex_q;
    rec_o.dec      = {bcd_a_q, bcd_b_q, bcd_c_q};
    rec_o.bits     = bits_q;
    rec_o.btn      = btn_q;
    rec_o.csum_bcd = cbcd_q[11:0];
  end

  // Checksum: four frame bytes per group
  assign grp_base = ste_pkg::IDX_W'(3) + {cnt_q, 2'b00};
  always_comb begin
    grp_sum = '0;
    for (int k = 0; k < 4; k++) begin
      grp_sum = grp_sum + ste_pkg::SUM_W'(ste_pkg::byte_at(rec_o,
                  grp_base + ste_pkg::IDX_W'(k)));
    end
  end
  assign sum_big = (sum_q >= ste_pkg::SUM_W'(ste_pkg::CSUM_MOD));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ste_pkg::F_IDLE:  if (hold_valid_q) state_d = ste_pkg::F_CONV;
      ste_pkg::F_CONV:  if (cnt_q == 4'(ste_pkg::ANA_W - 1)) state_d = ste_pkg::F_SUM;
      ste_pkg::F_SUM:   if (cnt_q == 4'(ste_pkg::GROUPS - 1)) state_d = ste_pkg::F_MOD;
      ste_pkg::F_MOD:   if (!sum_big) state_d = ste_pkg::F_CCONV;
      ste_pkg::F_CCONV: if (cnt_q == 4'(ste_pkg::SEQ_W - 1)) state_d = ste_pkg::F_PUSH;
      ste_pkg::F_PUSH:  if (!q_stat_i.full) state_d = ste_pkg::F_IDLE;
      default:          state_d = ste_pkg::F_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    take   = 1'b0;
    push_o = 1'b0;
    case (state_q)
      ste_pkg::F_IDLE: take   = hold_valid_q;
      ste_pkg::F_PUSH: push_o = !q_stat_i.full;
      default: ;
    endcase
  end

  // Step counter
  always_comb begin
    cnt_d = cnt_q;
    case (state_q)
      ste_pkg::F_IDLE:  cnt_d = '0;
      ste_pkg::F_CONV:  cnt_d = (cnt_q == 4'(ste_pkg::ANA_W - 1)) ? '0 : cnt_q + 4'd1;
      ste_pkg::F_SUM:   cnt_d = (cnt_q == 4'(ste_pkg::GROUPS - 1)) ? '0 : cnt_q + 4'd1;
      ste_pkg::F_MOD:   cnt_d = '0;
      ste_pkg::F_CCONV: cnt_d = cnt_q + 4'd1;
      default:          cnt_d = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ste_pkg::F_IDLE;
      hold_valid_q <= 1'b0;
      cnt_q        <= '0;
      seq_bin_q    <= '0;
      seq_bcd_q    <= '0;
    end else begin
      state_q      <= state_d;
      hold_valid_q <= hold_valid_d;
      cnt_q        <= cnt_d;
      // sequence number advances once per queued frame
      if (push_o) begin
        if (seq_bin_q == ste_pkg::SEQ_W'(ste_pkg::SEQ_MODULUS - 1)) begin
          seq_bin_q <= '0;
          seq_bcd_q <= '0;
        end else begin
          seq_bin_q <= seq_bin_q + 1'b1;
          if (seq_bcd_q[3:0] != 4'd9) begin
            seq_bcd_q[3:0] <= seq_bcd_q[3:0] + 4'd1;
          end else begin
            seq_bcd_q[3:0] <= 4'd0;
            if (seq_bcd_q[7:4] != 4'd9) begin
              seq_bcd_q[7:4] <= seq_bcd_q[7:4] + 4'd1;
            end else begin
              seq_bcd_q[7:4]  <= 4'd0;
              seq_bcd_q[11:8] <= seq_bcd_q[11:8] + 4'd1;
            end
          end
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      hold_q <= s_tdata_i;
    end
    case (state_q)
      ste_pkg::F_IDLE: begin
        if (take) begin
          hex_q   <= {hold_q[15:0], hold_q[31:16], hold_q[47:32]};
          sh_a_q  <= hold_q[59:48];
          sh_b_q  <= hold_q[71:60];
          sh_c_q  <= hold_q[83:72];
          bits_q  <= hold_q[91:84];
          btn_q   <= hold_q[92];
          bcd_a_q <= '0;
          bcd_b_q <= '0;
          bcd_c_q <= '0;
          sum_q   <= '0;
        end
      end
      ste_pkg::F_CONV: begin
        bcd_a_q <= ste_pkg::bcd_step(bcd_a_q, sh_a_q[ste_pkg::ANA_W-1]);
        bcd_b_q <= ste_pkg::bcd_step(bcd_b_q, sh_b_q[ste_pkg::ANA_W-1]);
        bcd_c_q <= ste_pkg::bcd_step(bcd_c_q, sh_c_q[ste_pkg::ANA_W-1]);
        sh_a_q  <= {sh_a_q[ste_pkg::ANA_W-2:0], 1'b0};
        sh_b_q  <= {sh_b_q[ste_pkg::ANA_W-2:0], 1'b0};
        sh_c_q  <= {sh_c_q[ste_pkg::ANA_W-2:0], 1'b0};
      end
      ste_pkg::F_SUM: begin
        sum_q <= sum_q + grp_sum;
      end
      ste_pkg::F_MOD: begin
        if (sum_big) begin
          sum_q <= sum_q - ste_pkg::SUM_W'(ste_pkg::CSUM_MOD);
        end else begin
          csh_q  <= sum_q[ste_pkg::SEQ_W-1:0];
          cbcd_q <= '0;
        end
      end
      ste_pkg::F_CCONV: begin
        cbcd_q <= ste_pkg::bcd_step(cbcd_q, csh_q[ste_pkg::SEQ_W-1]);
        csh_q  <= {csh_q[ste_pkg::SEQ_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // a set is only taken out of the holding register when one is there
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> hold_valid_q)
    else $error("front took an empty holding register");

  // a record is never offered to a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_stat_i.full)
    else $error("front pushed into a full queue");

  // sequence number stays below its modulus
  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_bin_q < ste_pkg::SEQ_W'(ste_pkg::SEQ_MODULUS))
    else $error("sequence number out of range");
`endif

endmodule

// ----- rtl/ste_queue.sv -----
// ----------------------------------------------------------------------------
// ste_queue: record queue
// Small first-in first-out queue of converted frame records between the
// converter and the serializer.
// ----------------------------------------------------------------------------
module ste_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ste_pkg::frame_rec_t  rec_i,
  input  logic                 pop_i,
  output ste_pkg::frame_rec_t  rec_o,
  output ste_pkg::q_stat_t     stat_o
);

  ste_pkg::frame_rec_t          mem_q [ste_pkg::Q_DEPTH];
  logic [ste_pkg::Q_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ste_pkg::Q_CW-1:0]     count_q;

  assign stat_o.full  = (count_q == ste_pkg::Q_CW'(ste_pkg::Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign rec_o        = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ste_pkg::Q_CW'(ste_pkg::Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/ste_back.sv -----
// ----------------------------------------------------------------------------
// ste_back: frame serializer
// Takes one converted record from the queue and sends its 44 ASCII bytes,
// one per cycle while the sink is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module ste_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ste_pkg::q_stat_t            q_stat_i,
  input  ste_pkg::frame_rec_t         rec_i,
  output logic                        pop_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [ste_pkg::BYTE_W-1:0]  m_tdata_o,
  output logic                        m_tlast_o
);

  ste_pkg::frame_rec_t           cur_q;
  logic                          active_q;
  logic [ste_pkg::IDX_W-1:0]     idx_q;
  logic                          valid_q;
  logic [ste_pkg::BYTE_W-1:0]    data_q;
  logic                          last_q;
  logic                          load;
  logic                          last_byte;

  // Output stage advances when empty or drained
  assign load      = !valid_q || m_tready_i;
  assign last_byte = active_q && (idx_q == ste_pkg::IDX_W'(ste_pkg::FRAME_LEN - 1));
  assign pop_o     = !q_stat_i.empty && (!active_q || (load && last_byte));

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= active_q;
        last_q  <= last_byte;
      end
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (load && active_q) begin
        idx_q <= idx_q + 1'b1;
        if (last_byte) active_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= rec_i;
    end
    if (load && active_q) begin
      data_q <= ste_pkg::byte_at(cur_q, idx_q);
    end
  end

`ifndef ASSERT_OFF
  // the flagged byte always closes the frame with a line feed
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tlast_o) |-> (m_tdata_o == ste_pkg::CH_LF))
    else $error("frame end flag on a byte other than line feed");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (idx_q <= ste_pkg::IDX_W'(ste_pkg::FRAME_LEN - 1)))
    else $error("byte index past frame end");

  // a new record is only fetched once the previous frame is done
  a_pop_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!active_q || last_byte))
    else $error("serializer fetched mid-frame");
`endif

endmodule

// ----- rtl/sensor_telemetry_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// sensor_telemetry_frame_encoder: ASCII telemetry frame generator
// Turns one sensor sample set into a 44-byte CR LF terminated ASCII frame.
// ----------------------------------------------------------------------------
// Each accepted sample set produces one 44-byte frame on the output stream,
// one byte per request, tlast on the closing line feed. The serializer sends
// a byte every cycle while the sink is ready, so the sustained rate of sample
// sets is bounded by the byte-wide output. The front converter runs 12
// double-dabble steps for the readings, 9 checksum groups, up to 3 modulo
// steps and 10 steps for the checksum digits, and works on the next set
// while the current frame is still streaming; a two-entry record queue and
// an input holding register let the input accept a new set while earlier
// ones are in flight. The sequence number starts at 0 after reset and wraps
// from 999 to 0.
module sensor_telemetry_frame_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], analog_a[59:48],
  //        analog_b[71:60], analog_c[83:72], digital_bits[91:84],
  //        button_level[92], zero pad[95:93]
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [ste_pkg::IN_W-1:0]    s_axis_tdata_i,
  // tdata: frame_byte[7:0]; tlast: frame_end
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [ste_pkg::BYTE_W-1:0]  m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  logic                 push;
  logic                 pop;
  ste_pkg::frame_rec_t  rec_in;
  ste_pkg::frame_rec_t  rec_out;
  ste_pkg::q_stat_t     q_stat;

  ste_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i[ste_pkg::IN_USED-1:0]),
    .push_o     (push),
    .rec_o      (rec_in),
    .q_stat_i   (q_stat)
  );

  ste_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .pop_i  (pop),
    .rec_o  (rec_out),
    .stat_o (q_stat)
  );

  ste_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .rec_i      (rec_out),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
